// ----- hw/rtl/tmie_pkg.sv -----
// Shared types and constants of the tape-machine instruction executor.
// No dependencies; every other file of the block but tmie_checker imports this package.
package tmie_pkg;

  // Tape and loop stack geometry
  localparam int unsigned TAPE_CELLS  = 32768;
  localparam int unsigned LOOP_DEPTH  = 1024;
  localparam int unsigned HEAD_W      = $clog2(TAPE_CELLS);
  localparam int unsigned TOP_W       = $clog2(LOOP_DEPTH + 1);
  localparam int unsigned SADDR_W     = (LOOP_DEPTH > 1) ? $clog2(LOOP_DEPTH) : 1;

  // Skip nesting counter
  localparam int unsigned SKIP_W      = 11;
  localparam logic [SKIP_W-1:0] SKIP_MAX = 11'd2047;

  // Field widths
  localparam int unsigned CELL_W      = 8;
  localparam int unsigned IDX_W       = 16;
  localparam int unsigned VAL_W       = 32;
  localparam logic [CELL_W-1:0] CELL_MAX_RST = 8'd127;

  // Queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Classified operation; unused action codes become a no-op
  typedef enum logic [3:0] {
    OP_LEFT       = 4'd0,
    OP_RIGHT      = 4'd1,
    OP_INC        = 4'd2,
    OP_DEC        = 4'd3,
    OP_OUTPUT     = 4'd4,
    OP_INPUT      = 4'd5,
    OP_LOOP_START = 4'd6,
    OP_LOOP_END   = 4'd7,
    OP_BANANA     = 4'd8,
    OP_NOP        = 4'd9
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_OVERFLOW  = 2'd1,
    STAT_UNDERFLOW = 2'd2
  } status_e;

  // One queued instruction: operation, position and clamped input value
  typedef struct packed {
    op_e                op;
    logic [IDX_W-1:0]   idx;
    logic [CELL_W-1:0]  val;
  } item_t;

  // Status from back part to front part
  typedef struct packed {
    logic               clearing;
    logic [CELL_W-1:0]  cell_max;
  } back_stat_t;

endpackage

// ----- hw/rtl/tmie_front.sv -----
// Front part: accepts instruction beats, classifies the action and clamps
// the input value to the cell range. Depends on tmie_pkg.
module tmie_front (
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [3:0]                action_i,
  input  logic [15:0]               instr_index_i,
  input  logic signed [31:0]        in_value_i,
  input  tmie_pkg::back_stat_t      stat_i,
  input  logic                      q_ready_i,
  output logic                      q_push_o,
  output tmie_pkg::item_t           q_item_o
);
  import tmie_pkg::*;

  logic [VAL_W-1:0]  raw;
  logic [CELL_W-1:0] clamped;
  op_e               op;

  assign raw = in_value_i;

  // Clamp to 0..cell_max
  always_comb begin
    if (raw[VAL_W-1]) begin
      clamped = '0;
    end else if (raw > {{(VAL_W-CELL_W){1'b0}}, stat_i.cell_max}) begin
      clamped = stat_i.cell_max;
    end else begin
      clamped = raw[CELL_W-1:0];
    end
  end

  // Classify action, codes past banana are no-ops
  always_comb begin
    if (action_i inside {[4'd0:4'd8]}) begin
      op = op_e'(action_i);
    end else begin
      op = OP_NOP;
    end
  end

  // No beat is taken while the tape is being cleared
  assign in_ready_o  = q_ready_i && !stat_i.clearing;
  assign q_push_o    = in_valid_i && in_ready_o;
  assign q_item_o.op  = op;
  assign q_item_o.idx = instr_index_i;
  assign q_item_o.val = clamped;

endmodule

// ----- hw/rtl/tmie_queue.sv -----
// Short queue of classified instructions between front and back parts.
// Depends on tmie_pkg for the item type and depth.
module tmie_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             ready_o,
  input  tmie_pkg::item_t  item_i,
  output logic             valid_o,
  input  logic             pop_i,
  output tmie_pkg::item_t  item_o
);
  import tmie_pkg::*;

  item_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign ready_o = (cnt_q != QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;
  assign item_o  = mem_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// ----- hw/rtl/tmie_back.sv -----
// Back part: owns tape, head, loop stack, skip counter and cell_max, and
// carries out each instruction in a fetch state and then an execute state.
// Depends on tmie_pkg.
module tmie_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic [7:0]            cfg_data_i,
  input  logic                  q_valid_i,
  input  tmie_pkg::item_t       q_item_i,
  output logic                  q_pop_o,
  output tmie_pkg::back_stat_t  stat_o,
  output logic                  res_valid_o,
  input  logic                  res_ready_i,
  output logic [15:0]           next_index_o,
  output logic                  out_valid_o,
  output logic [7:0]            out_char_o,
  output logic                  banana_seen_o,
  output logic                  skipping_o,
  output logic [1:0]            status_o
);
  import tmie_pkg::*;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_FETCH,
    S_EXEC
  } state_e;

  localparam logic [HEAD_W-1:0] HEAD_LAST = HEAD_W'(TAPE_CELLS - 1);

  // Memories
  logic [CELL_W-1:0] tape_mem  [TAPE_CELLS];
  logic [IDX_W-1:0]  stack_mem [LOOP_DEPTH];

  state_e            state_q, state_d;
  logic [HEAD_W-1:0] clr_cnt_q, clr_cnt_d;
  logic [HEAD_W-1:0] head_q, head_d;
  logic [TOP_W-1:0]  top_q, top_d;
  logic [SKIP_W-1:0] skip_q, skip_d;
  logic [CELL_W-1:0] cell_max_q, cell_max_d;

  item_t             cur_q;
  logic [CELL_W-1:0] cell_rd_q;
  logic [IDX_W-1:0]  stk_rd_q;
  logic [SADDR_W-1:0] stk_ra;

  logic              tape_we;
  logic [HEAD_W-1:0] tape_wa;
  logic [CELL_W-1:0] tape_wd;
  logic              stk_we;

  logic              res_vld_q, res_vld_d;
  logic [IDX_W-1:0]  next_q, next_d;
  logic              ov_q, ov_d;
  logic [CELL_W-1:0] ch_q, ch_d;
  logic              ban_q, ban_d;
  logic              skp_q, skp_d;
  status_e           st_q, st_d;

  logic              pop;
  logic [CELL_W-1:0] cur_cell;

  assign cur_cell = cell_rd_q;
  assign pop  = (state_q == S_FETCH) && q_valid_i && (!res_vld_q || res_ready_i);
  assign q_pop_o = pop;
  assign stk_ra  = (top_q == '0) ? '0 : SADDR_W'(top_q - TOP_W'(1));

  assign stat_o.clearing = (state_q == S_CLEAR);
  assign stat_o.cell_max = cell_max_q;

  // Sequencing, execution and result
  always_comb begin
    state_d    = state_q;
    clr_cnt_d  = clr_cnt_q;
    head_d     = head_q;
    top_d      = top_q;
    skip_d     = skip_q;
    cell_max_d = cfg_valid_i ? cfg_data_i : cell_max_q;
    tape_we    = 1'b0;
    tape_wa    = head_q;
    tape_wd    = '0;
    stk_we     = 1'b0;
    res_vld_d  = res_vld_q && !res_ready_i;
    next_d     = next_q;
    ov_d       = ov_q;
    ch_d       = ch_q;
    ban_d      = ban_q;
    skp_d      = skp_q;
    st_d       = st_q;

    case (state_q)
      // Zero the tape, one cell a cycle
      S_CLEAR: begin
        tape_we   = 1'b1;
        tape_wa   = clr_cnt_q;
        clr_cnt_d = clr_cnt_q + HEAD_W'(1);
        if (clr_cnt_q == HEAD_LAST) begin
          state_d = S_FETCH;
        end
      end
      S_FETCH: begin
        if (pop) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_FETCH;
        next_d  = cur_q.idx + IDX_W'(1);
        ov_d    = 1'b0;
        ch_d    = '0;
        ban_d   = 1'b0;
        st_d    = STAT_OK;
        if (skip_q != '0) begin
          // Inside a skipped loop only nesting is tracked
          case (cur_q.op)
            OP_LOOP_START: begin
              if (skip_q != SKIP_MAX) begin
                skip_d = skip_q + SKIP_W'(1);
              end
            end
            OP_LOOP_END: skip_d = skip_q - SKIP_W'(1);
            default: ;
          endcase
        end else begin
          case (cur_q.op)
            OP_LEFT:  head_d = (head_q == '0) ? HEAD_LAST : head_q - HEAD_W'(1);
            OP_RIGHT: head_d = (head_q == HEAD_LAST) ? '0 : head_q + HEAD_W'(1);
            OP_INC: begin
              tape_we = 1'b1;
              tape_wd = (cur_cell >= cell_max_q) ? '0 : cur_cell + CELL_W'(1);
            end
            OP_DEC: begin
              tape_we = 1'b1;
              tape_wd = (cur_cell == '0) ? cell_max_q : cur_cell - CELL_W'(1);
            end
            OP_OUTPUT: begin
              ov_d = 1'b1;
              ch_d = cur_cell;
            end
            OP_INPUT: begin
              tape_we = 1'b1;
              tape_wd = cur_q.val;
            end
            OP_LOOP_START: begin
              if (cur_cell == '0) begin
                skip_d = SKIP_W'(1);
              end else if (top_q == TOP_W'(LOOP_DEPTH)) begin
                st_d = STAT_OVERFLOW;
              end else begin
                stk_we = 1'b1;
                top_d  = top_q + TOP_W'(1);
              end
            end
            OP_LOOP_END: begin
              if (top_q == '0) begin
                st_d = STAT_UNDERFLOW;
              end else if (cur_cell == '0) begin
                top_d = top_q - TOP_W'(1);
              end else begin
                next_d = stk_rd_q + IDX_W'(1);
              end
            end
            OP_BANANA: ban_d = 1'b1;
            default: ;
          endcase
        end
        skp_d     = (skip_d != '0);
        res_vld_d = 1'b1;
      end
      default: state_d = S_CLEAR;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      clr_cnt_q  <= '0;
      head_q     <= '0;
      top_q      <= '0;
      skip_q     <= '0;
      cell_max_q <= CELL_MAX_RST;
      res_vld_q  <= 1'b0;
      next_q     <= '0;
      ov_q       <= 1'b0;
      ch_q       <= '0;
      ban_q      <= 1'b0;
      skp_q      <= 1'b0;
      st_q       <= STAT_OK;
    end else begin
      state_q    <= state_d;
      clr_cnt_q  <= clr_cnt_d;
      head_q     <= head_d;
      top_q      <= top_d;
      skip_q     <= skip_d;
      cell_max_q <= cell_max_d;
      res_vld_q  <= res_vld_d;
      next_q     <= next_d;
      ov_q       <= ov_d;
      ch_q       <= ch_d;
      ban_q      <= ban_d;
      skp_q      <= skp_d;
      st_q       <= st_d;
    end
  end

  // Current instruction
  always_ff @(posedge clk_i) begin
    if (pop) begin
      cur_q <= q_item_i;
    end
  end

  // Tape: read under the head at fetch, write at execute or clear
  always_ff @(posedge clk_i) begin
    if (tape_we) begin
      tape_mem[tape_wa] <= tape_wd;
    end
    if (pop) begin
      cell_rd_q <= tape_mem[head_q];
    end
  end

  // Loop stack: read top entry at fetch, push at execute
  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stack_mem[top_q[SADDR_W-1:0]] <= cur_q.idx;
    end
    if (pop) begin
      stk_rd_q <= stack_mem[stk_ra];
    end
  end

  assign res_valid_o   = res_vld_q;
  assign next_index_o  = next_q;
  assign out_valid_o   = ov_q;
  assign out_char_o    = ch_q;
  assign banana_seen_o = ban_q;
  assign skipping_o    = skp_q;
  assign status_o      = st_q;

endmodule

// ----- hw/rtl/tape_machine_instruction_executor.sv -----
// Top level of the tape-machine instruction executor: front, queue, back.
// Depends on tmie_pkg, tmie_front, tmie_queue and tmie_back.
//
// After reset the block zeroes its 32768-cell tape one cell a cycle, and no
// instruction beat is taken until the tape is clear; cell_max writes are
// taken at any time (cfg_ready_o is always high). Instructions enter a
// two-entry queue at up to one beat a cycle while it has room. The back
// part handles each in a fetch state that reads the tape cell under the
// head and the top loop stack entry from their synchronous memories, and
// an execute state that writes the cell back and loads the result register.
// No new instruction is fetched before the last one is executed, due to
// that read-modify-write of the tape; the result register holds one result
// while the next is fetched, and one result is given for each instruction.
module tape_machine_instruction_executor (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [7:0]         cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [3:0]         action_i,
  input  logic [15:0]        instr_index_i,
  input  logic signed [31:0] in_value_i,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output logic [15:0]        next_index_o,
  output logic               out_valid_o,
  output logic [7:0]         out_char_o,
  output logic               banana_seen_o,
  output logic               skipping_o,
  output logic [1:0]         status_o
);
  import tmie_pkg::*;

  back_stat_t stat;
  item_t      push_item;
  item_t      pop_item;
  logic       q_ready;
  logic       q_push;
  logic       q_valid;
  logic       q_pop;

  assign cfg_ready_o = 1'b1;

  tmie_front u_front (
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .action_i      (action_i),
    .instr_index_i (instr_index_i),
    .in_value_i    (in_value_i),
    .stat_i        (stat),
    .q_ready_i     (q_ready),
    .q_push_o      (q_push),
    .q_item_o      (push_item)
  );

  tmie_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .ready_o (q_ready),
    .item_i  (push_item),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .item_o  (pop_item)
  );

  tmie_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_data_i    (cfg_data_i),
    .q_valid_i     (q_valid),
    .q_item_i      (pop_item),
    .q_pop_o       (q_pop),
    .stat_o        (stat),
    .res_valid_o   (res_valid_o),
    .res_ready_i   (res_ready_i),
    .next_index_o  (next_index_o),
    .out_valid_o   (out_valid_o),
    .out_char_o    (out_char_o),
    .banana_seen_o (banana_seen_o),
    .skipping_o    (skipping_o),
    .status_o      (status_o)
  );

endmodule

// ----- hw/rtl/tmie_checker.sv -----
// Port-level checks of the tape-machine instruction executor, bound to the
// top level. Depends only on the top level's ports.
module tmie_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               res_valid_o,
  input  logic               res_ready_i,
  input  logic [15:0]        next_index_o,
  input  logic               out_valid_o,
  input  logic [7:0]         out_char_o,
  input  logic               banana_seen_o,
  input  logic               skipping_o,
  input  logic [1:0]         status_o
);

  // A stalled result beat holds
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_ready_i |=> res_valid_o && $stable(next_index_o)
      && $stable(out_char_o) && $stable(status_o))
    else $error("result beat changed while stalled");

  // A loop stack fault comes from a loop instruction outside a skip
  a_fault_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && (status_o != 2'd0) |-> !skipping_o && !out_valid_o && !banana_seen_o)
    else $error("stack fault reported with another event");

  // Status code three is never produced
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> status_o != 2'd3)
    else $error("undefined status code");

  // Character is zero unless this is an output instruction
  a_char_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !out_valid_o |-> out_char_o == 8'd0 && !(out_valid_o && banana_seen_o))
    else $error("character present without output event");

endmodule

bind tape_machine_instruction_executor tmie_checker u_checker (.*);
